[rtl/swmd_pkg.sv]
// ============================================================================
// Sync word message deframer package
// Shared types and constants for the deframer front end, queue and output stage.
// ============================================================================
package swmd_pkg;

   // Parse phase of the header state machine.
   typedef enum logic [1:0] {
      PH_SYNC    = 2'd0,
      PH_HDR     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_HUNT    = 2'd3
   } phase_type;

   // Result kind codes as they appear on the result channel.
   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BAD_SYNC = 2'd2,
      KIND_TOO_LONG = 2'd3
   } kind_type;

   // Configuration register indexes.
   localparam logic CSR_SYNC_WORD   = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   // Header layout: sync word, message id and length, four bytes each.
   localparam int HEADER_BYTES = 4 + 4 + 4;
   localparam logic [3:0] SYNC_LAST_COUNT = 4'd3;
   localparam logic [3:0] ID_END_COUNT    = 4'd8;
   localparam logic [3:0] HDR_LAST_COUNT  = 4'(HEADER_BYTES - 1);
   localparam logic [3:0] HUNT_COUNT      = 4'd4;

   // Result queue between the front end and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One result as it travels from the front end to the output stage.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] message_id;
      logic [7:0]  payload_byte;
      logic        first_byte;
      logic        last_byte;
   } result_type;

endpackage

[rtl/swmd_front.sv]
// ============================================================================
// Deframer front end
// Holds the configuration registers, parses the header byte by byte, hunts for
// the sync word after an error and classifies the bytes into results.
// ============================================================================
module swmd_front import swmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata,
   output logic        push_valid,
   output result_type  push_item,
   input  logic        push_ready
);

   logic [31:0] sync_word_ff;
   logic [30:0] max_len_ff;

   phase_type   phase_ff, phase_in;
   logic [31:0] window_ff, window_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic [30:0] rem_ff, rem_in;

   logic        accept;
   logic [31:0] window_shift;
   logic [31:0] id_shift;
   logic [31:0] len_shift;
   logic        sync_match;
   logic        len_too_big;
   logic        len_zero;

   assign req_tready   = push_ready;
   assign accept       = req_tvalid && push_ready;
   assign window_shift = {window_ff[23:0], req_tdata};
   assign id_shift     = {id_ff[23:0], req_tdata};
   assign len_shift    = {len_ff[23:0], req_tdata};
   assign sync_match   = (window_shift == sync_word_ff);
   assign len_too_big  = (len_shift > {1'b0, max_len_ff});
   assign len_zero     = (len_shift == '0);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff <= '0;
         max_len_ff   <= '1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SYNC_WORD:   sync_word_ff <= csr_wdata;
            CSR_MAX_PAYLOAD: max_len_ff   <= csr_wdata[30:0];
            default:         sync_word_ff <= sync_word_ff;
         endcase
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC: begin
               if (count_ff == SYNC_LAST_COUNT) begin
                  phase_in = sync_match ? PH_HDR : PH_HUNT;
               end
            end
            PH_HUNT: begin
               if (sync_match) begin
                  phase_in = PH_HDR;
               end
            end
            PH_HDR: begin
               if (count_ff == HDR_LAST_COUNT) begin
                  if (len_too_big) begin
                     phase_in = PH_HUNT;
                  end else if (len_zero) begin
                     phase_in = PH_SYNC;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (rem_ff <= 31'd1) begin
                  phase_in = PH_SYNC;
               end
            end
            default: phase_in = PH_SYNC;
         endcase
      end
   end

   // Datapath updates and result classification.
   always_comb begin
      window_in  = window_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      push_valid = 1'b0;
      push_item  = '{kind: KIND_DATA, message_id: id_ff, payload_byte: 8'd0,
                     first_byte: 1'b0, last_byte: 1'b0};
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC: begin
               window_in = window_shift;
               count_in  = count_ff + 4'd1;
               if (count_ff == SYNC_LAST_COUNT && !sync_match) begin
                  count_in             = '0;
                  push_valid           = 1'b1;
                  push_item.kind       = KIND_BAD_SYNC;
                  push_item.message_id = '0;
               end
            end
            PH_HUNT: begin
               window_in = window_shift;
               if (sync_match) begin
                  count_in = HUNT_COUNT;
               end
            end
            PH_HDR: begin
               window_in = window_shift;
               count_in  = count_ff + 4'd1;
               if (count_ff < ID_END_COUNT) begin
                  id_in = id_shift;
               end else begin
                  len_in = len_shift;
               end
               if (count_ff == HDR_LAST_COUNT) begin
                  count_in = '0;
                  rem_in   = len_shift[30:0];
                  if (len_too_big) begin
                     push_valid     = 1'b1;
                     push_item.kind = KIND_TOO_LONG;
                  end else if (len_zero) begin
                     push_valid          = 1'b1;
                     push_item.kind      = KIND_EMPTY;
                     push_item.last_byte = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               push_valid             = 1'b1;
               push_item.payload_byte = req_tdata;
               push_item.first_byte   = ({1'b0, rem_ff} == len_ff);
               push_item.last_byte    = (rem_ff <= 31'd1);
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 31'd1;
               end
               if (rem_ff <= 31'd1) begin
                  count_in = '0;
               end
            end
            default: count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC;
         window_ff <= '0;
         count_ff  <= '0;
         id_ff     <= '0;
         len_ff    <= '0;
         rem_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         rem_ff    <= rem_in;
      end
   end

   // A payload phase always has bytes left to take.
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> rem_ff != '0)
      else $error("payload phase with no bytes remaining");

   // A bad sync word always starts the hunt.
   a_bad_sync_hunts: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_item.kind == KIND_BAD_SYNC |=> phase_ff == PH_HUNT)
      else $error("bad sync result without entering hunt");

   // The header count is parked at zero while hunting.
   a_hunt_count_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> count_ff == '0)
      else $error("header count not cleared during hunt");

endmodule

[rtl/swmd_queue.sv]
// ============================================================================
// Deframer result queue
// Short FIFO that lets the front end and the output stage stall independently.
// ============================================================================
module swmd_queue import swmd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  result_type push_item,
   output logic       push_ready,
   output logic       pop_valid,
   output result_type pop_item,
   input  logic       pop_ready
);

   localparam logic [QUEUE_CNT_W-1:0] QueueFull = QUEUE_CNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0] PtrStep   = QUEUE_PTR_W'(1);
   localparam logic [QUEUE_CNT_W-1:0] CntStep   = QUEUE_CNT_W'(1);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != QueueFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrStep : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrStep : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntStep;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntStep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueFull)
      else $error("queue count beyond depth");

   // Pointers and count stay consistent: equal pointers mean empty or full.
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == rd_ptr_ff |-> (count_ff == '0 || count_ff == QueueFull))
      else $error("queue pointers disagree with count");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == QueueFull && !do_pop |=> count_ff == QueueFull)
      else $error("full queue lost an entry");

endmodule

[rtl/swmd_back.sv]
// ============================================================================
// Deframer output stage
// Registers the head of the result queue onto the result channel and holds it
// until the receiver takes it.
// ============================================================================
module swmd_back import swmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  result_type  pop_item,
   output logic        pop_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic       valid_ff, valid_in;
   result_type item_ff;
   logic       load;

   assign load      = !valid_ff || rsp_tready;
   assign pop_ready = load;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         item_ff <= pop_item;
      end
   end

   // Payload byte is forced to zero on anything but a data result.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(item_ff.kind == KIND_DATA) ? item_ff.payload_byte : 8'd0,
                        item_ff.message_id};
   assign rsp_tuser  = {item_ff.first_byte, item_ff.kind};
   assign rsp_tlast  = item_ff.last_byte;

endmodule

[rtl/sync_word_message_deframer.sv]
// ============================================================================
// Sync word message deframer
// Splits a byte stream into sync-word framed, length-prefixed messages.
// ============================================================================
// The request channel takes one received byte per word. Each message is a
// 12-byte big-endian header (sync word, message id, payload length) followed
// by the payload. Every payload byte comes out as one result word tagged with
// the message id and first/last marks. A zero-length message yields one empty
// result; a bad sync word or an oversized length yields one error result, after
// which the block hunts byte by byte for the sync word. Header and hunt bytes
// that end no check produce no result.
// Throughput is one byte per cycle while the queue is not full; the header state
// machine advances on every accepted byte. Each result is written into the queue
// when its byte is accepted and is then loaded from the queue into the output
// register, which holds it on the result channel until the receiver takes it. The
// four queue entries plus the output register hold five results while the
// receiver stalls; the request side is backpressured only when the queue is full.
// Reset clears the parser to wait for a sync word, sets sync_word to zero and
// max_payload_length to its largest value, and empties the queue. The csr port
// writes register 0 (sync word) or 1 (maximum payload length).
// ============================================================================
module sync_word_message_deframer import swmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel. tdata: in_byte[7:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // message_id[31:0], payload_byte[39:32]
   output logic [2:0]  rsp_tuser,   // kind[1:0], first_byte[2]
   output logic        rsp_tlast,   // last_byte
   // Configuration write port.
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);

   logic       push_valid;
   logic       push_ready;
   result_type push_item;
   logic       pop_valid;
   logic       pop_ready;
   result_type pop_item;

   // Front end: configuration, header parsing and classification.
   swmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // Result queue decouples the parser from response-side stalls.
   swmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   // Output register on the response channel.
   swmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
